// ----- src/bpsa_pkg.sv -----
package bpsa_pkg;

  localparam int WORD_BITS      = 32;
  localparam int PAGE_BYTES     = 4096;
  localparam int PAGE_SHIFT     = 12;
  localparam int BIT_W          = 5;
  localparam int DEF_SLOT_COUNT = 2048;

  // request operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_FREED     = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_DISABLED  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLED   = 2'd0;
  localparam logic [1:0] CFG_POOL_BASE = 2'd1;
  localparam logic [1:0] CFG_POOL_END  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [31:0] slot_address;
    logic [2:0]  status;
  } out_item_t;

  // shared adder / subtractor request and response
  typedef struct packed {
    logic        sub;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        carry;
    logic [31:0] value;
  } alu_rsp_t;

  // lowest clear bit of a map word
  function automatic logic [BIT_W-1:0] find_first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ----- src/bpsa_ram.sv -----
module bpsa_ram
  import bpsa_pkg::*;
#(
  parameter int WIDTH = WORD_BITS,
  parameter int DEPTH = DEF_SLOT_COUNT / WORD_BITS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/bpsa_alu.sv -----
module bpsa_alu
  import bpsa_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [32:0] sum;

  // for a subtract, carry out set means a >= b
  assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {32'd0, req.sub};
  assign rsp.carry = sum[32];
  assign rsp.value = sum[31:0];

endmodule

// ----- src/bitmap_page_slot_allocator.sv -----
// sequence: a disabled request goes straight to its result, a free checks the bounds
//   (refused early when outside the pool), allocate scans the map (one word a cycle)
// throughput: one request at a time; the map ram's single read port and the
//   word-by-word scan bound the allocate time, the shared adder the free time
// reset: synchronous, active low; afterwards a clearing pass writes zero to
//   every map word, during which no request is taken
module bitmap_page_slot_allocator
  import bpsa_pkg::*;
#(
  parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // map geometry
  localparam int MAP_WORDS = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SLOT_W    = WORD_W + BIT_W;
  localparam int TAIL_BITS = SLOT_COUNT % WORD_BITS;
  // bits past the last slot in the final word always read as used
  localparam logic [WORD_BITS-1:0] TAIL_MASK =
    (TAIL_BITS == 0) ? '0 : ~((WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1));
  // byte span of the whole pool
  localparam logic [31:0] POOL_SPAN = 32'(SLOT_COUNT) << PAGE_SHIFT;

  typedef enum logic [9:0] {
    S_CLEAR    = 10'b0000000001,
    S_IDLE     = 10'b0000000010,
    S_SCAN     = 10'b0000000100,
    S_ADDR     = 10'b0000001000,
    S_FCHK_LO  = 10'b0000010000,
    S_FCHK_HI  = 10'b0000100000,
    S_FCHK_IDX = 10'b0001000000,
    S_FWR      = 10'b0010000000,
    S_RESP     = 10'b0100000000,
    S_SPARE    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic        enabled_r;
  logic [31:0] pool_base_r;
  logic [31:0] pool_end_r;

  // request working registers
  logic [31:0]       addr_r;
  logic [31:0]       diff_r, diff_nxt;
  logic [31:0]       slot_addr_r, slot_addr_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [WORD_W-1:0] clr_r;
  logic [WORD_W:0]   scan_rd_r;
  logic              rd_pend_r;
  logic [WORD_W-1:0] chk_idx_r;
  logic [SLOT_W-1:0] found_slot_r;

  // result output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // map ram
  logic                 ram_we;
  logic [WORD_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // shared adder
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  // scan and free decode
  logic                 scan_last;
  logic [WORD_BITS-1:0] scan_word;
  logic                 scan_hit;
  logic [BIT_W-1:0]     found_bit;
  logic [WORD_W-1:0]    free_word;
  logic [BIT_W-1:0]     free_bit;
  logic                 in_take;

  bpsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WORD_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpsa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // word under check in the scan, with the unused tail forced to used
  assign scan_last = (chk_idx_r == WORD_W'(MAP_WORDS - 1));
  assign scan_word = ram_rdata | (scan_last ? TAIL_MASK : '0);
  assign scan_hit  = rd_pend_r && (scan_word != '1);
  assign found_bit = find_first_zero(scan_word);

  // slot being freed, from the offset into the pool
  assign free_word = WORD_W'(diff_r >> (PAGE_SHIFT + BIT_W));
  assign free_bit  = diff_r[PAGE_SHIFT +: BIT_W];

  // adder operand select, one use per sequencer step
  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = addr_r;
    alu_req.b   = pool_base_r;
    unique case (state_r)
      S_FCHK_HI: begin
        alu_req.b = pool_end_r;
      end
      S_FCHK_IDX: begin
        alu_req.a = diff_r;
        alu_req.b = POOL_SPAN;
      end
      S_ADDR: begin
        alu_req.sub = 1'b0;
        alu_req.a   = pool_base_r;
        alu_req.b   = 32'(found_slot_r) << PAGE_SHIFT;
      end
      default: begin
      end
    endcase
  end

  // map ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_word;
    ram_wdata = ram_rdata & ~(WORD_BITS'(1) << free_bit);
    ram_raddr = free_word;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_SCAN: begin
        ram_raddr = scan_rd_r[WORD_W-1:0];
        ram_waddr = chk_idx_r;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << found_bit);
        ram_we    = scan_hit;
      end
      S_FWR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    diff_nxt      = diff_r;
    slot_addr_nxt = slot_addr_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == WORD_W'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          slot_addr_nxt = '0;
          if (!enabled_r) begin
            status_nxt = ST_DISABLED;
            state_nxt  = S_RESP;
          end else if (in_data.operation == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FCHK_LO;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_ADDR;
        end else if (rd_pend_r && scan_last) begin
          status_nxt = ST_EXHAUSTED;
          state_nxt  = S_RESP;
        end
      end
      S_ADDR: begin
        slot_addr_nxt = alu_rsp.value;
        status_nxt    = ST_ALLOCATED;
        state_nxt     = S_RESP;
      end
      S_FCHK_LO: begin
        // below pool_base
        diff_nxt = alu_rsp.value;
        if (!alu_rsp.carry) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_FCHK_HI;
        end
      end
      S_FCHK_HI: begin
        // at or past pool_end
        if (alu_rsp.carry) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_FCHK_IDX;
        end
      end
      S_FCHK_IDX: begin
        // slot index beyond the map; the map word read is issued here
        if (alu_rsp.carry) begin
          status_nxt = ST_OUTSIDE;
          state_nxt  = S_RESP;
        end else begin
          state_nxt = S_FWR;
        end
      end
      S_FWR: begin
        status_nxt = ST_FREED;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      scan_rd_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      enabled_r   <= 1'b0;
      pool_base_r <= '0;
      pool_end_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + WORD_W'(1);
      end

      // scan read issue, one map word a cycle
      if (state_r == S_SCAN) begin
        if (scan_rd_r < (WORD_W + 1)'(MAP_WORDS)) begin
          scan_rd_r <= scan_rd_r + (WORD_W + 1)'(1);
          rd_pend_r <= 1'b1;
        end else begin
          rd_pend_r <= 1'b0;
        end
      end else begin
        scan_rd_r <= '0;
        rd_pend_r <= 1'b0;
      end

      // a new result loads as the old one leaves
      if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ENABLED:   enabled_r   <= cfg_data[0];
          CFG_POOL_BASE: pool_base_r <= cfg_data;
          CFG_POOL_END:  pool_end_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    diff_r      <= diff_nxt;
    slot_addr_r <= slot_addr_nxt;
    if (in_take) begin
      addr_r <= in_data.address;
    end
    if (state_r == S_SCAN) begin
      chk_idx_r <= scan_rd_r[WORD_W-1:0];
    end
    if (scan_hit && state_r == S_SCAN) begin
      found_slot_r <= {chk_idx_r, found_bit};
    end
    if (state_r == S_RESP && (!out_valid_r || !out_stall)) begin
      out_data_r.slot_address <= slot_addr_r;
      out_data_r.status       <= status_r;
    end
  end

  // a result only appears out of the response step
  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response step");

  // only an allocation carries a non-zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_ALLOCATED) |-> (out_data_r.slot_address == '0))
    else $error("non-zero address on a non-allocate result");

  // the map is never written while waiting for a request
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !ram_we)
    else $error("map written outside a request");

  // scan never checks a word past the map
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_pend_r) |-> (32'(chk_idx_r) < 32'(MAP_WORDS)))
    else $error("scan past the end of the map");

endmodule

// ----- tb/bitmap_page_slot_allocator_tb.sv -----
`timescale 1ns / 1ps

module bitmap_page_slot_allocator_tb;
  import bpsa_pkg::*;

  localparam int SLOTS         = DEF_SLOT_COUNT;
  localparam int LONG_HOLD     = 400;   // receiver hold-off long enough to back the block up
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake at all before giving up
  localparam int SETTLE_CYCLES = 100;   // above the slowest allocate scan
  // index past the last register, must be ignored by the block
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // clock and block inputs, all known from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_ready;

  // own copy of the pool registers and the used-slot map
  logic             pool_enabled = 1'b0;
  logic [31:0]      pool_base_q  = '0;
  logic [31:0]      pool_end_q   = '0;
  logic [SLOTS-1:0] slot_used    = '0;

  in_item_t  pending_requests[$];   // requests waiting to be offered
  out_item_t awaited_results[$];    // results owed by the block, oldest first
  out_item_t due;

  // pacing knobs, set by the sequence below
  int unsigned sender_idle_pct  = 21;
  int unsigned recv_idle_pct    = 83;
  bit          sender_hold      = 1'b0;
  int          long_holds_asked = 0;
  int          long_holds_done  = 0;
  int          hold_left        = 0;

  logic in_fire       = 1'b0;
  int   mismatch_count = 0;
  int   exhausted_seen = 0;
  int   quiet_cycles   = 0;
  int   live_guess     = 0;   // rough count of slots held, steers frees towards used slots

  bitmap_page_slot_allocator #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // expected result of one request; updates the slot map as the block should
  function automatic out_item_t slot_outcome(input in_item_t req);
    out_item_t   res;
    logic [31:0] offset;
    logic [31:0] slot;
    res.slot_address = '0;
    res.status       = ST_DISABLED;
    if (!pool_enabled) return res;
    if (req.operation == OP_ALLOC) begin
      // first fit: lowest clear bit wins, address wraps at 32 bits
      res.status = ST_EXHAUSTED;
      for (int s = 0; s < SLOTS; s++) begin
        if (!slot_used[s]) begin
          slot_used[s]     = 1'b1;
          res.slot_address = pool_base_q + 32'(s) * 32'(PAGE_BYTES);
          res.status       = ST_ALLOCATED;
          break;
        end
      end
    end else begin
      // outside the window, or an index past the map, leaves the map alone
      res.status = ST_OUTSIDE;
      if (req.address >= pool_base_q && req.address < pool_end_q) begin
        offset = req.address - pool_base_q;
        slot   = offset >> PAGE_SHIFT;
        if (slot < SLOTS) begin
          slot_used[slot] = 1'b0;   // cleared even when already clear
          res.status      = ST_FREED;
        end
      end
    end
    return res;
  endfunction

  // request side: a new request only once the previous one has gone
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (!sender_hold && pending_requests.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // accepted requests feed the prediction
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      awaited_results.push_back(slot_outcome(in_data));
    end
  end

  // result side: random stall, plus long hold-offs counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds_done < long_holds_asked) begin
      out_stall       <= 1'b1;
      hold_left       <= LONG_HOLD;
      long_holds_done <= long_holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // result checker, field by field against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (out_data.status == ST_EXHAUSTED) exhausted_seen <= exhausted_seen + 1;
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data.slot_address);
      end else begin
        due = awaited_results.pop_front();
        if (out_data.slot_address !== due.slot_address) begin
          report_mismatch("slot_address", due.slot_address, out_data.slot_address);
        end
        if (out_data.status !== due.status) begin
          report_mismatch("status", 32'(due.status), 32'(out_data.status));
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one register write; the local copy follows once the block takes it
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ENABLED:   pool_enabled = value[0];
      CFG_POOL_BASE: pool_base_q  = value;
      CFG_POOL_END:  pool_end_q   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pool(input logic [31:0] base, input logic [31:0] lim);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_POOL_END, lim);
  endtask

  task automatic queue_one(input logic op, input logic [31:0] addr);
    in_item_t req;
    req.operation = op;
    req.address   = addr;
    pending_requests.push_back(req);
  endtask

  // random requests; most frees aim at slots likely to be held
  task automatic queue_requests(input int count, input int unsigned alloc_pct);
    in_item_t    req;
    logic [31:0] span;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      req.address   = $urandom;
      req.operation = OP_ALLOC;
      if ($urandom_range(99) >= alloc_pct) begin
        req.operation = OP_FREE;
        span = pool_end_q - pool_base_q;
        pick = $urandom_range(99);
        if (pick < 55) begin
          req.address = pool_base_q + 32'($urandom_range(live_guess)) * 32'(PAGE_BYTES) +
                        32'($urandom_range(PAGE_BYTES - 1));
          if (live_guess > 0) live_guess--;
        end else if (pick < 75) begin
          req.address = (span != 0) ? pool_base_q + ($urandom % span) : pool_base_q;
        end else if (pick < 90) begin
          case ($urandom_range(3))
            0: req.address = pool_base_q - 32'd1;
            1: req.address = pool_end_q;
            2: req.address = pool_end_q - 32'd1;
            default: req.address = pool_base_q;
          endcase
        end
      end else if (live_guess < SLOTS - 1) begin
        live_guess++;
      end
      pending_requests.push_back(req);
    end
  endtask

  // until every queued request has been answered (queue left alone while held)
  task automatic wait_results_settled();
    do @(posedge clk);
    while (in_valid || awaited_results.size() != 0 ||
           (!sender_hold && pending_requests.size() != 0));
  endtask

  // request sequence
  initial begin
    logic [31:0] base;
    int          rounds;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // straight out of reset: pool not initialised, both requests refused
    queue_one(OP_ALLOC, 32'h0000_0000);
    queue_one(OP_FREE, 32'hFFFF_FFFF);
    wait_results_settled();
    // write to a non-existent register must not enable anything
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    queue_one(OP_ALLOC, 32'hFFFF_FFFF);
    wait_results_settled();

    // pool of exactly the map's size
    set_pool(32'h8000_0000, 32'h8080_0000);
    write_reg(CFG_ENABLED, 32'h0000_0001);
    queue_one(OP_ALLOC, 32'h0);
    queue_one(OP_ALLOC, 32'h0);
    queue_one(OP_ALLOC, 32'h0);
    queue_one(OP_FREE, 32'h8000_1FFF);   // rounds down to slot one
    queue_one(OP_ALLOC, 32'h0);          // slot one comes back first
    queue_one(OP_FREE, 32'h8006_4000);   // slot never taken, still freed
    queue_one(OP_FREE, 32'h7FFF_FFFF);   // just below the pool
    queue_one(OP_FREE, 32'h8080_0000);   // pool end is exclusive
    queue_one(OP_FREE, 32'h807F_FFFF);   // last byte of the last slot
    queue_one(OP_FREE, 32'hFFFF_FFFF);
    queue_one(OP_ALLOC, 32'hFFFF_FFFF);
    wait_results_settled();

    // pool at the top of the address space, allocations wrap past 2^32
    set_pool(32'hFFFF_F000, 32'hFFFF_FFFF);
    queue_one(OP_FREE, 32'hFFFF_F000);
    queue_one(OP_ALLOC, 32'h0);
    queue_one(OP_ALLOC, 32'h0);
    wait_results_settled();

    // window wider than the map: indexes past the last slot refused
    set_pool(32'h0000_0000, 32'hFFFF_FFFF);
    queue_one(OP_FREE, 32'h0080_0000);
    queue_one(OP_FREE, 32'hFFFF_FFFE);
    queue_one(OP_FREE, 32'h0000_0FFF);
    wait_results_settled();

    // empty and inverted windows admit nothing
    set_pool(32'h0000_1000, 32'h0000_1000);
    queue_one(OP_FREE, 32'h0000_1000);
    wait_results_settled();
    write_reg(CFG_POOL_END, 32'h0000_0000);
    queue_one(OP_FREE, 32'h0000_1800);
    wait_results_settled();

    // switched off again
    write_reg(CFG_ENABLED, 32'h0000_0000);
    queue_one(OP_ALLOC, 32'h0);
    queue_one(OP_FREE, 32'h0000_1000);
    wait_results_settled();

    // random, busy sender against a mostly stalled receiver
    set_pool(32'h4000_0000, 32'h4080_0000);
    write_reg(CFG_ENABLED, 32'h0000_0001);
    queue_requests(350, 85);
    wait_results_settled();

    // roles swapped, random page-aligned window of varying span
    sender_idle_pct = 83;
    recv_idle_pct   = 21;
    base = $urandom & 32'hFFFF_F000;
    set_pool(base, base + 32'($urandom_range(1, 4096)) * 32'(PAGE_BYTES));
    queue_requests(200, 80);
    while (pending_requests.size() > 100) @(posedge clk);
    // sender stands back until the block has answered everything
    sender_hold = 1'b1;
    wait_results_settled();
    sender_hold = 1'b0;
    wait_results_settled();

    // pool disabled by a write with only the upper bits set
    write_reg(CFG_ENABLED, 32'hFFFF_FFFE);
    queue_requests(40, 50);
    wait_results_settled();
    write_reg(CFG_ENABLED, 32'h0000_0001);

    // arbitrary, unaligned bounds
    set_pool($urandom, $urandom);
    queue_requests(150, 80);
    wait_results_settled();

    // no idling: fill the map until allocation runs dry
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    base = $urandom & 32'hFFFF_F000;
    set_pool(base, base + 32'h0080_0000);
    long_holds_asked++;   // receiver backs off while requests keep coming
    queue_requests(300, 97);
    wait_results_settled();
    rounds = 0;
    while (exhausted_seen < 40 && rounds < 20) begin
      queue_requests(150, 97);
      wait_results_settled();
      rounds++;
    end
    // churn on a nearly full map
    queue_requests(150, 55);
    wait_results_settled();

    // extreme bounds: base at the very top, end at zero
    set_pool(32'hFFFF_FFFF, 32'h0000_0000);
    queue_requests(30, 50);
    wait_results_settled();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
